// ===== rtl/core/pisr_pkg.sv =====
// package: types and constants of the pin interrupt subscription router
`timescale 1ns / 1ps
`default_nettype none
package pisr_pkg;

   localparam logic [1:0] MODE_IRQ   = 2'd0;
   localparam logic [1:0] MODE_SUB   = 2'd1;
   localparam logic [1:0] MODE_UNSUB = 2'd2;
   localparam logic [1:0] MODE_NONE  = 2'd3;

   localparam logic [2:0] KIND_NOTIFY  = 3'd0;
   localparam logic [2:0] KIND_CONFIG  = 3'd1;
   localparam logic [2:0] KIND_BADPIN  = 3'd2;
   localparam logic [2:0] KIND_UNCONF  = 3'd3;
   localparam logic [2:0] KIND_FULL    = 3'd4;

   localparam int WINDOW_W = 24;
   localparam int TIME_W   = 64;

   typedef struct packed {
      logic [1:0]  mode;
      logic [4:0]  pin;
      logic [3:0]  events;
      logic [63:0] timestamp;
      logic [7:0]  requester_host;
      logic [7:0]  requester_task;
      logic        pull_down;
      logic [23:0] debounce_time;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] dest_host;
      logic [7:0] dest_task;
      logic [4:0] pin_out;
      logic [3:0] event_bits;
      logic       pull_out;
      logic       pin_configure;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  host;
      logic [7:0]  task_id;
      logic [3:0]  events;
      logic [23:0] window;
      logic [63:0] last_time;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_EVAL,
      ST_SHIFT,
      ST_DONE
   } exec_state_type;

   function automatic logic pin_is_valid(input logic [4:0] p);
      return (p <= 5'd22) || (p >= 5'd26 && p <= 5'd28);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/pisr_if.sv =====
// interface: valid/ready channel carrying one item
`timescale 1ns / 1ps
`default_nettype none
interface pisr_if #(parameter type PAYLOAD_TYPE = logic);
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/pisr_ram.sv =====
// generic ram with one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none
module pisr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

// ===== rtl/core/pisr_front.sv =====
// front end: accepts items and queues them for the executor
`timescale 1ns / 1ps
`default_nettype none
module pisr_front
   import pisr_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   pisr_if.sink      req,
   output req_type   q_item,
   output logic      q_valid,
   input  wire logic q_pop
);
   // two-entry queue, mode 3 dropped at entry
   req_type  buf_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push;

   assign req.ready = (cnt_ff != 2'd2);
   assign push = req.valid && req.ready && (req.payload.mode != MODE_NONE);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = buf_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      rd_in = rd_ff;
      wr_in = wr_ff;
      if (push) wr_in = ~wr_ff;
      if (q_pop && q_valid) rd_in = ~rd_ff;
      if (push && !(q_pop && q_valid)) cnt_in = cnt_ff + 2'd1;
      else if (!push && q_pop && q_valid) cnt_in = cnt_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) buf_ff[wr_ff] <= req.payload;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset) cnt_ff <= 2'd2)
      else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("push into full queue");
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
endmodule
`default_nettype wire

// ===== rtl/core/pisr_exec.sv =====
// back end: walks the pin's slots and produces result items
`timescale 1ns / 1ps
`default_nettype none
module pisr_exec
   import pisr_pkg::*;
#(
   parameter int PIN_COUNT = 32,
   parameter int SLOTS_PER_PIN = 8
) (
   input  wire logic clock,
   input  wire logic reset,
   input  req_type   q_item,
   input  wire logic q_valid,
   output logic      q_pop,
   pisr_if.source    rsp
);
   localparam int SW = (SLOTS_PER_PIN > 1) ? $clog2(SLOTS_PER_PIN) : 1;
   localparam int CW = $clog2(SLOTS_PER_PIN + 1);
   localparam int PW = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
   localparam int TOTAL = PIN_COUNT * SLOTS_PER_PIN;
   localparam int AW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
   localparam logic [CW-1:0] SLOTS = CW'(SLOTS_PER_PIN);

   exec_state_type st_ff, st_in;
   logic [PIN_COUNT-1:0] ready_ff, ready_in, pull_ff, pull_in;
   logic [CW-1:0] used_ff [PIN_COUNT];
   logic [CW-1:0] used_in;
   logic          used_we;
   logic [CW-1:0] s_ff, s_in;
   logic [CW-1:0] found_ff, found_in;
   logic [3:0]    mask_ff, mask_in;
   req_type       it_ff;
   logic          take;
   logic [PW-1:0] pidx;

   rsp_type ob_ff, ob_in;
   logic    ov_ff, ov_in;
   // pending notify held for last marking
   rsp_type pend_ff, pend_in;
   logic    pv_ff, pv_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   slot_type      wr_data, rd_data;
   logic [SW-1:0] s_lo;

   pisr_ram #(.WIDTH(SLOT_W), .DEPTH(TOTAL)) u_ram (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign pidx = PW'(it_ff.pin);
   assign s_lo = s_ff[SW-1:0];
   assign rsp.valid = ov_ff;
   assign rsp.payload = ob_ff;

   function automatic logic [AW-1:0] addr_of(input logic [PW-1:0] p, input logic [CW-1:0] s);
      return AW'(p) * AW'(SLOTS_PER_PIN) + AW'(s);
   endfunction

   logic [CW-1:0] n;
   logic          outfree;
   logic [64:0]   lim;
   logic          pass, pinok;

   always_comb begin
      n = used_ff[pidx];
      outfree = !ov_ff || rsp.ready;
      pinok = pin_is_valid(it_ff.pin) && (32'(it_ff.pin) < PIN_COUNT);
      lim = {1'b0, rd_data.last_time} + 65'(rd_data.window);
      pass = (rd_data.window == '0) || (!lim[64] && it_ff.timestamp > lim[63:0]);
   end

   always_comb begin
      st_in = st_ff;
      ready_in = ready_ff;
      pull_in = pull_ff;
      used_in = n;
      used_we = 1'b0;
      s_in = s_ff;
      found_in = found_ff;
      mask_in = mask_ff;
      ob_in = ob_ff;
      ov_in = ov_ff && !rsp.ready;
      pend_in = pend_ff;
      pv_in = pv_ff;
      take = 1'b0;
      q_pop = 1'b0;
      wr_en = 1'b0;
      wr_addr = addr_of(pidx, s_ff);
      wr_data = rd_data;
      rd_addr = addr_of(pidx, s_ff);
      case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               take = 1'b1;
               q_pop = 1'b1;
               s_in = '0;
               found_in = SLOTS;
               mask_in = '0;
               st_in = ST_READ;
            end
         end
         ST_READ: begin
            if (!pinok) begin
               if (outfree) begin
                  ob_in = '0;
                  ob_in.kind = KIND_BADPIN;
                  ob_in.pin_out = it_ff.pin;
                  ob_in.pull_out = (32'(it_ff.pin) < PIN_COUNT) ? pull_ff[pidx] : 1'b1;
                  if (it_ff.mode != MODE_IRQ) begin
                     ob_in.dest_host = it_ff.requester_host;
                     ob_in.dest_task = it_ff.requester_task;
                  end
                  ob_in.last = 1'b1;
                  ov_in = 1'b1;
                  st_in = ST_IDLE;
               end
            end else if (it_ff.mode == MODE_IRQ && !ready_ff[pidx]) begin
               st_in = ST_IDLE;
            end else if (it_ff.mode == MODE_UNSUB && !ready_ff[pidx]) begin
               if (outfree) begin
                  ob_in = '0;
                  ob_in.kind = KIND_UNCONF;
                  ob_in.dest_host = it_ff.requester_host;
                  ob_in.dest_task = it_ff.requester_task;
                  ob_in.pin_out = it_ff.pin;
                  ob_in.pull_out = pull_ff[pidx];
                  ob_in.last = 1'b1;
                  ov_in = 1'b1;
                  st_in = ST_IDLE;
               end
            end else if (s_ff >= n) begin
               st_in = ST_DONE;
            end else begin
               st_in = ST_WAIT;
            end
         end
         ST_WAIT: st_in = ST_EVAL;
         ST_EVAL: begin
            if (it_ff.mode == MODE_IRQ) begin
               if (((rd_data.events & it_ff.events) != '0) && pass) begin
                  if (!pv_ff || outfree) begin
                     if (pv_ff) begin
                        ob_in = pend_ff;
                        ov_in = 1'b1;
                     end
                     pend_in = '0;
                     pend_in.kind = KIND_NOTIFY;
                     pend_in.dest_host = rd_data.host;
                     pend_in.dest_task = rd_data.task_id;
                     pend_in.pin_out = it_ff.pin;
                     pend_in.event_bits = it_ff.events;
                     pend_in.pull_out = pull_ff[pidx];
                     pv_in = 1'b1;
                     wr_en = 1'b1;
                     wr_data.last_time = it_ff.timestamp;
                     s_in = s_ff + 1'b1;
                     st_in = ST_READ;
                  end
               end else begin
                  s_in = s_ff + 1'b1;
                  st_in = ST_READ;
               end
            end else if (it_ff.mode == MODE_UNSUB && found_ff != SLOTS) begin
               // shifting slots down after a delete
               wr_addr = addr_of(pidx, s_ff - 1'b1);
               wr_en = 1'b1;
               mask_in = mask_ff | rd_data.events;
               s_in = s_ff + 1'b1;
               st_in = ST_READ;
            end else if (rd_data.host == it_ff.requester_host &&
                         rd_data.task_id == it_ff.requester_task) begin
               found_in = s_ff;
               if (it_ff.mode == MODE_SUB) begin
                  wr_en = 1'b1;
                  wr_data.events = it_ff.events;
                  mask_in = mask_ff | it_ff.events;
               end
               s_in = s_ff + 1'b1;
               st_in = ST_READ;
            end else begin
               mask_in = mask_ff | rd_data.events;
               s_in = s_ff + 1'b1;
               st_in = ST_READ;
            end
         end
         ST_SHIFT: st_in = ST_IDLE;
         ST_DONE: begin
            if (it_ff.mode == MODE_IRQ) begin
               if (!pv_ff) st_in = ST_IDLE;
               else if (outfree) begin
                  ob_in = pend_ff;
                  ob_in.last = 1'b1;
                  ov_in = 1'b1;
                  pv_in = 1'b0;
                  st_in = ST_IDLE;
               end
            end else if (it_ff.mode == MODE_SUB && found_ff == SLOTS && n >= SLOTS) begin
               if (outfree) begin
                  ob_in = '0;
                  ob_in.kind = KIND_FULL;
                  ob_in.dest_host = it_ff.requester_host;
                  ob_in.dest_task = it_ff.requester_task;
                  ob_in.pin_out = it_ff.pin;
                  ob_in.pull_out = pull_ff[pidx];
                  ob_in.last = 1'b1;
                  ov_in = 1'b1;
                  st_in = ST_IDLE;
               end
            end else if (outfree) begin
               ob_in = '0;
               ob_in.kind = KIND_CONFIG;
               ob_in.dest_host = it_ff.requester_host;
               ob_in.dest_task = it_ff.requester_task;
               ob_in.pin_out = it_ff.pin;
               ob_in.pull_out = pull_ff[pidx];
               ob_in.event_bits = mask_ff;
               ob_in.last = 1'b1;
               ov_in = 1'b1;
               st_in = ST_IDLE;
               if (it_ff.mode == MODE_SUB && found_ff == SLOTS) begin
                  wr_en = 1'b1;
                  wr_addr = addr_of(pidx, n);
                  wr_data.host = it_ff.requester_host;
                  wr_data.task_id = it_ff.requester_task;
                  wr_data.events = it_ff.events;
                  wr_data.window = it_ff.debounce_time;
                  wr_data.last_time = '0;
                  used_in = n + 1'b1;
                  used_we = 1'b1;
                  ob_in.event_bits = mask_ff | it_ff.events;
                  if (!ready_ff[pidx]) begin
                     ready_in[pidx] = 1'b1;
                     pull_in[pidx] = it_ff.pull_down;
                     ob_in.pull_out = it_ff.pull_down;
                     ob_in.pin_configure = 1'b1;
                  end
               end else if (it_ff.mode == MODE_UNSUB && found_ff != SLOTS) begin
                  used_in = n - 1'b1;
                  used_we = 1'b1;
               end
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ready_ff <= '0;
         pull_ff <= '1;
         ov_ff <= 1'b0;
         pv_ff <= 1'b0;
         for (int i = 0; i < PIN_COUNT; i++) used_ff[i] <= '0;
      end else begin
         st_ff <= st_in;
         ready_ff <= ready_in;
         pull_ff <= pull_in;
         ov_ff <= ov_in;
         pv_ff <= pv_in;
         if (used_we) used_ff[pidx] <= used_in;
      end
      s_ff <= s_in;
      found_ff <= found_in;
      mask_ff <= mask_in;
      ob_ff <= ob_in;
      pend_ff <= pend_in;
      if (take) it_ff <= q_item;
   end

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> st_ff == ST_IDLE) else $error("pop outside idle");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_we |-> used_in <= SLOTS) else $error("slot count overflow");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      ov_ff && !rsp.ready |=> ov_ff && $stable(ob_ff)) else $error("result dropped");
   a_idle_nopend: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_IDLE |-> !pv_ff) else $error("pending notify left");
   a_slot_idx: assert property (@(posedge clock) disable iff (reset)
      st_ff == ST_EVAL |-> s_ff < SLOTS) else $error("slot index out of range");
endmodule
`default_nettype wire

// ===== rtl/core/pin_interrupt_subscription_router.sv =====
// top level: pin interrupt subscription router
// req channel carries requests: mode 0 interrupt, 1 subscribe, 2 unsubscribe.
// rsp channel carries result items, last set on the final one of each request.
// a two-entry queue decouples intake from the executor, so req is ready
// while the executor works on an earlier request.
// the executor reads the pin's subscriber slots one at a time through
// the ram's read port (address, registered read, evaluate), for up to
// SLOTS_PER_PIN subscribers (8 by default); a bad pin answers without
// a walk, as does an unsubscribe on an unconfigured pin; an interrupt there is dropped.
// notifications are held one step so the last one can be flagged.
// unsubscribe shifts later slots down during the same walk.
// reset is synchronous: pins unconfigured, pull set high, tables empty;
// slot contents need no clearing since per-pin counts track occupancy.
// a stalled rsp holds its item; the executor waits, the queue fills and
// then req.ready drops.
`timescale 1ns / 1ps
`default_nettype none
module pin_interrupt_subscription_router
   import pisr_pkg::*;
#(
   parameter int PIN_COUNT = 32,
   parameter int SLOTS_PER_PIN = 8
) (
   input wire logic clock,
   input wire logic reset,
   pisr_if.sink     req,
   pisr_if.source   rsp
);
   req_type q_item;
   logic    q_valid, q_pop;

   pisr_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
   );

   pisr_exec #(.PIN_COUNT(PIN_COUNT), .SLOTS_PER_PIN(SLOTS_PER_PIN)) u_exec (
      .clock(clock), .reset(reset), .q_item(q_item), .q_valid(q_valid),
      .q_pop(q_pop), .rsp(rsp)
   );
endmodule
`default_nettype wire
